// ----- rtl/kre_pkg.sv -----
package kre_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [4:0] HoldCap   = 5'd20;
  localparam logic [3:0] RepeatCap = 4'd15;
  localparam logic [4:0] GravCap   = 5'd31;
  localparam logic [4:0] LevelFast = 5'd14;
  localparam logic [4:0] DropNeed  = 5'd1;
  localparam logic [4:0] UpNeed    = 5'd1;
  localparam logic [4:0] PauseNeed = 5'd2;

  localparam logic [3:0] RepeatThresholdReset = 4'd3;
  localparam logic [3:0] RepeatRestartReset   = 4'd1;
  localparam logic [4:0] GravityBaseReset     = 5'd15;

  localparam int unsigned NumEvents = 8;

  typedef enum logic [1:0] {
    CFG_REPEAT_THRESHOLD = 2'd0,
    CFG_REPEAT_RESTART   = 2'd1,
    CFG_GRAVITY_BASE     = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    EV_LEFT    = 3'd0,
    EV_RIGHT   = 3'd1,
    EV_DOWN    = 3'd2,
    EV_DROP    = 3'd3,
    EV_UP      = 3'd4,
    EV_PAUSE   = 3'd5,
    EV_GRAVITY = 3'd6,
    EV_REFRESH = 3'd7
  } event_code_t;

  typedef struct packed {
    logic       left_button;
    logic       left_shoulder;
    logic       right_button;
    logic       right_shoulder;
    logic       down_button;
    logic       button_three;
    logic       up_button;
    logic       button_one;
    logic       button_two;
    logic       pause_button;
    logic       camera_on;
    logic [4:0] speed_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_of_tick;
  } out_item_t;

  typedef struct packed {
    logic [3:0] repeat_threshold;
    logic [3:0] repeat_restart;
    logic [4:0] gravity_base;
  } cfg_t;

  // One bit per event code; bit position equals the code.
  typedef logic [NumEvents-1:0] event_mask_t;

endpackage

// ----- rtl/kre_front.sv -----
module kre_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kre_pkg::in_item_t     in_data,
  input  kre_pkg::cfg_t         cfg,
  output logic                  push_valid,
  input  logic                  push_ready,
  output kre_pkg::event_mask_t  push_mask
);

  logic [3:0] left_hold_r, left_hold_nxt;
  logic [3:0] right_hold_r, right_hold_nxt;
  logic [3:0] down_hold_r, down_hold_nxt;
  logic [4:0] drop_hold_r, drop_hold_nxt;
  logic [4:0] up_hold_r, up_hold_nxt;
  logic [4:0] pause_hold_r, pause_hold_nxt;
  logic [4:0] grav_r, grav_nxt;
  logic       prev_cam_r, prev_cam_nxt;

  logic                 accept;
  kre_pkg::event_mask_t mask;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic       held_left, held_right, held_down, held_drop, held_up, held_pause;
    logic [3:0] inc4;
    logic [4:0] inc5;
    logic [4:0] period;
    logic       key_event;
    logic       grav_fire;

    held_left  = in_data.left_button | in_data.left_shoulder;
    held_right = in_data.right_button | in_data.right_shoulder;
    held_down  = in_data.down_button | in_data.button_three;
    held_drop  = in_data.button_three;
    held_up    = in_data.up_button | in_data.button_one | in_data.button_two;
    held_pause = in_data.pause_button;

    mask = '0;
    inc4 = '0;

    // Auto-repeat keys: count saturates, fires at threshold and reloads.
    left_hold_nxt = '0;
    if (held_left) begin
      inc4 = (left_hold_r < kre_pkg::RepeatCap) ? left_hold_r + 4'd1 : left_hold_r;
      if (inc4 >= cfg.repeat_threshold) begin
        left_hold_nxt = cfg.repeat_restart;
        mask[kre_pkg::EV_LEFT] = 1'b1;
      end else begin
        left_hold_nxt = inc4;
      end
    end

    right_hold_nxt = '0;
    if (held_right) begin
      inc4 = (right_hold_r < kre_pkg::RepeatCap) ? right_hold_r + 4'd1 : right_hold_r;
      if (inc4 >= cfg.repeat_threshold) begin
        right_hold_nxt = cfg.repeat_restart;
        mask[kre_pkg::EV_RIGHT] = 1'b1;
      end else begin
        right_hold_nxt = inc4;
      end
    end

    down_hold_nxt = '0;
    if (held_down) begin
      inc4 = (down_hold_r < kre_pkg::RepeatCap) ? down_hold_r + 4'd1 : down_hold_r;
      if (inc4 >= cfg.repeat_threshold) begin
        down_hold_nxt = cfg.repeat_restart;
        mask[kre_pkg::EV_DOWN] = 1'b1;
      end else begin
        down_hold_nxt = inc4;
      end
    end

    // Release keys fire once on release if they were held long enough.
    drop_hold_nxt = '0;
    if (held_drop) begin
      drop_hold_nxt = (drop_hold_r < kre_pkg::HoldCap) ? drop_hold_r + 5'd1 : kre_pkg::HoldCap;
    end else begin
      mask[kre_pkg::EV_DROP] = drop_hold_r > kre_pkg::DropNeed;
    end

    up_hold_nxt = '0;
    if (held_up) begin
      up_hold_nxt = (up_hold_r < kre_pkg::HoldCap) ? up_hold_r + 5'd1 : kre_pkg::HoldCap;
    end else begin
      mask[kre_pkg::EV_UP] = up_hold_r > kre_pkg::UpNeed;
    end

    pause_hold_nxt = '0;
    if (held_pause) begin
      pause_hold_nxt = (pause_hold_r < kre_pkg::HoldCap) ? pause_hold_r + 5'd1
                                                         : kre_pkg::HoldCap;
    end else begin
      mask[kre_pkg::EV_PAUSE] = pause_hold_r > kre_pkg::PauseNeed;
    end

    key_event = |mask[kre_pkg::EV_PAUSE:kre_pkg::EV_LEFT];

    // Gravity only advances on ticks without a key event.
    inc5      = (grav_r < kre_pkg::GravCap) ? grav_r + 5'd1 : grav_r;
    period    = cfg.gravity_base - in_data.speed_level;
    grav_fire = (in_data.speed_level > kre_pkg::LevelFast) ||
                (in_data.speed_level >= cfg.gravity_base) ||
                (inc5 >= period);
    grav_nxt  = grav_r;
    if (!key_event) begin
      grav_nxt = grav_fire ? 5'd0 : inc5;
      mask[kre_pkg::EV_GRAVITY] = grav_fire;
    end

    mask[kre_pkg::EV_REFRESH] = in_data.camera_on != prev_cam_r;
    prev_cam_nxt = in_data.camera_on;
  end

  assign push_valid = accept && (mask != '0);
  assign push_mask  = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_hold_r  <= '0;
      right_hold_r <= '0;
      down_hold_r  <= '0;
      drop_hold_r  <= '0;
      up_hold_r    <= '0;
      pause_hold_r <= '0;
      grav_r       <= '0;
      prev_cam_r   <= 1'b0;
    end else if (accept) begin
      left_hold_r  <= left_hold_nxt;
      right_hold_r <= right_hold_nxt;
      down_hold_r  <= down_hold_nxt;
      drop_hold_r  <= drop_hold_nxt;
      up_hold_r    <= up_hold_nxt;
      pause_hold_r <= pause_hold_nxt;
      grav_r       <= grav_nxt;
      prev_cam_r   <= prev_cam_nxt;
    end
  end

endmodule

// ----- rtl/kre_fifo.sv -----
module kre_fifo #(
  parameter int unsigned DEPTH = kre_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  kre_pkg::event_mask_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output kre_pkg::event_mask_t pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  kre_pkg::event_mask_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign push_ready = count_r != CntW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue occupancy exceeds its depth");
`endif

endmodule

// ----- rtl/kre_back.sv -----
module kre_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  kre_pkg::event_mask_t pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kre_pkg::out_item_t   out_data
);

  kre_pkg::event_mask_t rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kre_pkg::out_item_t   out_r, out_nxt;

  logic                 slot_free;
  logic                 advance;
  logic [2:0]           low_idx;
  kre_pkg::event_mask_t rem_clr;
  kre_pkg::event_mask_t rem_after;

  // Lowest pending bit is the next event in the fixed order.
  always_comb begin
    low_idx = '0;
    for (int i = kre_pkg::NumEvents - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_idx = 3'(i);
      end
    end
  end

  assign rem_clr   = rem_r & (rem_r - 1'b1);
  assign slot_free = !out_valid_r || out_ready;
  assign advance   = slot_free && (rem_r != '0);
  assign rem_after = advance ? rem_clr : rem_r;
  assign pop_ready = rem_after == '0;

  always_comb begin
    rem_nxt       = (pop_valid && pop_ready) ? pop_data : rem_after;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (advance) begin
      out_valid_nxt        = 1'b1;
      out_nxt.event_code   = low_idx;
      out_nxt.last_of_tick = rem_clr == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last_of_tick |-> rem_r != '0)
    else $error("event shown as not last but nothing remains for the tick");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_r.last_of_tick |=>
      out_valid_r && (out_r.event_code > $past(out_r.event_code)))
    else $error("events of one tick left out of order");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> rem_r != '0)
    else $error("an empty event set was taken from the queue");
`endif

endmodule

// ----- rtl/key_repeat_and_gravity_events.sv -----
// Each accepted tick is classified in the cycle it is transferred and queued as a set of events.
// Events leave one per cycle from a registered output while out_ready is high.
// A tick with n events gives n output events; a tick with no events is not queued,
// so input throughput is one tick per cycle while the event queue has room.
// Synchronous active-low reset clears all hold counters, the gravity counter, the camera
// flag, the queue and the output, and loads the register defaults 3, 1 and 15.
module key_repeat_and_gravity_events #(
  parameter int unsigned QUEUE_DEPTH = kre_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kre_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kre_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data
);

  kre_pkg::cfg_t        cfg_r;
  logic                 push_valid, push_ready;
  kre_pkg::event_mask_t push_mask;
  logic                 pop_valid, pop_ready;
  kre_pkg::event_mask_t pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_threshold <= kre_pkg::RepeatThresholdReset;
      cfg_r.repeat_restart   <= kre_pkg::RepeatRestartReset;
      cfg_r.gravity_base     <= kre_pkg::GravityBaseReset;
    end else if (cfg_we) begin
      case (cfg_index)
        kre_pkg::CFG_REPEAT_THRESHOLD: cfg_r.repeat_threshold <= cfg_data[3:0];
        kre_pkg::CFG_REPEAT_RESTART:   cfg_r.repeat_restart   <= cfg_data[3:0];
        kre_pkg::CFG_GRAVITY_BASE:     cfg_r.gravity_base     <= cfg_data;
        default: ;
      endcase
    end
  end

  kre_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_mask  (push_mask)
  );

  kre_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_mask),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  kre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
